// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by ray_convex_polyhedron_intersect_unit
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rcpi_pkg.sv
// ---------------------------------------------------------------------------
// rcpi_pkg
// Types and constants shared by the ray / convex polyhedron unit.
// ---------------------------------------------------------------------------
package rcpi_pkg;

    localparam int MAX_PLANES_DEF = 16;
    localparam logic [0:0] CMD_LOAD  = 1'b0;
    localparam logic [0:0] CMD_TRACE = 1'b1;
    localparam logic [0:0] CFG_PLANE_COUNT = 1'b0;
    localparam logic [0:0] CFG_THRESHOLD   = 1'b1;
    localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

    // Sequencer states of the trace engine.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_I,       // issue read of plane i
        ST_DOT_I,      // dot products of o and d with plane i
        ST_DIV_START,
        ST_DIV,
        ST_PT,         // hit point components
        ST_RD_J,       // issue read of plane j
        ST_DOT_J,      // dot of point with plane j
        ST_NEXT_I,
        ST_NRM_RD,
        ST_NRM_L2,
        ST_NRM_NORM,
        ST_SQRT,
        ST_NDIV_START,
        ST_NDIV,
        ST_OUT
    } state_t;

    // Result item.
    typedef struct packed {
        logic               hit;
        logic [30:0]        distance;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } result_t;

    // Floor of a 64-bit signed value shifted right by 16.
    function automatic logic signed [63:0] fshr16(input logic signed [63:0] v);
        fshr16 = v >>> 16;
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

// File: sv/rcpi_divider.sv
// ---------------------------------------------------------------------------
// rcpi_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rcpi_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);

    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;

    // Start loads the operands; then one shift-subtract step per cycle while busy.
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[63]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = 64'(trial - {1'b0, d_reg});
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // The result is valid whenever no division is running.
    assign done      = !busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// File: sv/ray_convex_polyhedron_intersect_unit.sv
// ---------------------------------------------------------------------------
// ray_convex_polyhedron_intersect_unit
// Ray against a convex polyhedron held as a table of face planes.
// ---------------------------------------------------------------------------
// Usage: the s_axis channel takes items. tuser is the command (0 load, 1
// trace); tdata packs plane_index, vec_x/y/z and dir_x/y/z. Each item gives
// exactly one result item on m_axis (tuser = hit, tdata = distance and the
// unit normal). Configuration goes through cfg_valid/cfg_ready with
// cfg_index 0 (plane_count) or 1 (parallel_threshold).
// One item at a time: a load result is valid the cycle after acceptance.
// A trace walks the planes, with up to two passes of the serial divider per
// plane and reads from the one-read-per-cycle plane memory, and computes the
// normal (prescale, square root and three divisions) when a face is hit.
// The next item is taken once the previous result has been accepted.
// Reset clears the control state and the configuration registers; plane
// memory contents are undefined until loaded. When m_axis_tready is low the
// result is held in the output register and no new item is taken.
// ---------------------------------------------------------------------------
module ray_convex_polyhedron_intersect_unit
#(
    parameter int MAX_PLANES = rcpi_pkg::MAX_PLANES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // plane_index[3:0], vec_x, vec_y, vec_z, dir_x, dir_y, dir_z; zero pad
    input  logic [199:0] s_axis_tdata,
    // command
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // distance[30:0], normal_x, normal_y, normal_z; zero pad
    output logic [127:0] m_axis_tdata,
    // hit
    output logic [0:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CW = $clog2(MAX_PLANES + 1);

    rcpi_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [4:0]  count_cfg_reg;
    logic [15:0] thr_reg;
    logic [CW-1:0] count_reg;

    // Plane memory, one entry holds x, y and z.
    logic [95:0] plane_mem [MAX_PLANES];
    logic [95:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic        wr_en;

    // Item registers.
    logic signed [31:0] o_reg [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] p_reg [3];
    logic signed [31:0] n_reg [3];

    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [1:0]    k_reg, k_next;
    logic [1:0]    nk;
    logic signed [63:0] acc_reg, acc_next, acc2_reg, acc2_next;
    logic signed [63:0] prod_a, prod_b;
    logic [30:0]   t_reg, t_next;
    logic          ok_reg, ok_next;
    logic          found_reg, found_next;
    logic [30:0]   best_reg, best_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [63:0]   ud_reg, ud_next, un_reg, un_next;
    logic          div_phase_reg, div_phase_next;

    // Normal unit registers.
    logic [63:0]   l2_reg, l2_next;
    logic [5:0]    sh_reg, sh_next;
    logic [63:0]   sq_res_reg, sq_res_next, sq_bit_reg, sq_bit_next;
    logic signed [31:0] nout_reg [3];
    logic signed [31:0] nout_next [3];

    // Divider.
    logic        div_start;
    logic [63:0] div_a, div_b, div_q, div_r;
    logic        div_done;

    // Output register.
    rcpi_pkg::result_t res_reg, res_next;
    logic        ovalid_reg, ovalid_next;
    logic        in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == rcpi_pkg::ST_IDLE) && !ovalid_reg;
    assign cfg_ready = 1'b1;
    assign wr_en = in_acc && (s_axis_tuser == rcpi_pkg::CMD_LOAD)
                   && (32'(s_axis_tdata[3:0]) < MAX_PLANES);

    // Configuration writes; count is clipped to the table size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= '0;
            thr_reg       <= 16'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rcpi_pkg::CFG_PLANE_COUNT: count_cfg_reg <= cfg_data[4:0];
                rcpi_pkg::CFG_THRESHOLD:   thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end
    assign count_reg = (32'(count_cfg_reg) > MAX_PLANES) ? CW'(MAX_PLANES)
                                                         : CW'(count_cfg_reg);

    // Plane memory: write on load, registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            plane_mem[IW'(s_axis_tdata[3:0])] <= s_axis_tdata[99:4];
        rd_data_reg <= plane_mem[rd_addr];
    end

    rcpi_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Component k of the current plane and its product term.
    logic signed [31:0] mem_comp;
    logic signed [31:0] mul_lhs, mul_rhs2;
    always_comb
    begin
        case (k_reg)
            2'd0:    mem_comp = rd_data_reg[31:0];
            2'd1:    mem_comp = rd_data_reg[63:32];
            default: mem_comp = rd_data_reg[95:64];
        endcase
        mul_lhs  = (state_reg == rcpi_pkg::ST_DOT_J) ? p_reg[k_reg] : o_reg[k_reg];
        mul_rhs2 = d_reg[k_reg];
        prod_a = 64'(mul_lhs) * 64'(mem_comp);
        prod_b = 64'(mul_rhs2) * 64'(mem_comp);
    end

    // While the squared length is summed, k runs one ahead of the component.
    assign nk = (state_reg == rcpi_pkg::ST_NRM_L2) ? k_reg - 2'd1 : k_reg;

    logic [63:0] abs_dn, abs_num;
    logic signed [63:0] num;
    logic signed [63:0] pt_sum;
    logic [63:0]   m_sq;
    logic [63:0]   mag_k;
    logic [63:0]   sq_try;
    always_comb
    begin
        num     = rcpi_pkg::ONE_Q16 - acc_reg;
        abs_dn  = acc2_reg[63] ? 64'(-acc2_reg) : 64'(acc2_reg);
        abs_num = num[63] ? 64'(-num) : 64'(num);
        pt_sum  = 64'(o_reg[k_reg]) + rcpi_pkg::fshr16(64'($signed({1'b0, t_reg}))
                  * 64'(d_reg[k_reg]));
        mag_k   = n_reg[nk][31] ? 64'(-64'(n_reg[nk])) : 64'(n_reg[nk]);
        m_sq    = mag_k * mag_k;
        sq_try  = sq_res_reg + sq_bit_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        acc2_next      = acc2_reg;
        t_next         = t_reg;
        ok_next        = ok_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        ud_next        = ud_reg;
        un_next        = un_reg;
        div_phase_next = div_phase_reg;
        l2_next        = l2_reg;
        sh_next        = sh_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        nout_next      = nout_reg;
        res_next       = res_reg;
        ovalid_next    = ovalid_reg;
        rd_addr        = i_reg[IW-1:0];
        div_start      = 1'b0;
        div_a          = un_reg;
        div_b          = ud_reg;
        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;
        case (state_reg)
            rcpi_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    i_next     = '0;
                    found_next = 1'b0;
                    if (s_axis_tuser == rcpi_pkg::CMD_TRACE)
                        state_next = rcpi_pkg::ST_NEXT_I;
                    else
                    begin
                        res_next    = '0;
                        ovalid_next = 1'b1;
                    end
                end
            end
            rcpi_pkg::ST_NEXT_I:
            begin
                if (i_reg == count_reg)
                    state_next = found_reg ? rcpi_pkg::ST_NRM_RD : rcpi_pkg::ST_OUT;
                else
                    state_next = rcpi_pkg::ST_RD_I;
            end
            rcpi_pkg::ST_RD_I:
            begin
                rd_addr    = i_reg[IW-1:0];
                k_next     = 2'd0;
                acc_next   = '0;
                acc2_next  = '0;
                state_next = rcpi_pkg::ST_DOT_I;
            end
            rcpi_pkg::ST_DOT_I:
            begin
                rd_addr   = i_reg[IW-1:0];
                acc_next  = acc_reg + rcpi_pkg::fshr16(prod_a);
                acc2_next = acc2_reg + rcpi_pkg::fshr16(prod_b);
                k_next    = k_reg + 2'd1;
                if (k_reg == 2'd2)
                    state_next = rcpi_pkg::ST_DIV_START;
            end
            rcpi_pkg::ST_DIV_START:
            begin
                k_next  = 2'd0;
                ud_next = abs_dn;
                un_next = abs_num;
                if (abs_dn <= 64'(thr_reg) || abs_dn == 64'd0 || num == 64'sd0
                    || ((num > 0) != (acc2_reg > 0)))
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = rcpi_pkg::ST_NEXT_I;
                end
                else
                begin
                    div_phase_next = 1'b0;
                    div_start      = 1'b1;
                    div_a          = abs_num;
                    div_b          = abs_dn;
                    state_next     = rcpi_pkg::ST_DIV;
                end
            end
            rcpi_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (!div_phase_reg)
                    begin
                        if (div_q >= 64'd32768)
                        begin
                            t_next     = 31'h7FFFFFFF;
                            state_next = rcpi_pkg::ST_PT;
                        end
                        else
                        begin
                            t_next         = {div_q[14:0], 16'd0};
                            div_phase_next = 1'b1;
                            div_start      = 1'b1;
                            div_a          = div_r << 16;
                            div_b          = ud_reg;
                        end
                    end
                    else
                    begin
                        t_next     = t_reg + 31'(div_q);
                        state_next = rcpi_pkg::ST_PT;
                    end
                end
            end
            rcpi_pkg::ST_PT:
            begin
                if (t_reg == 31'd0)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = rcpi_pkg::ST_NEXT_I;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd2)
                    begin
                        j_next     = '0;
                        ok_next    = 1'b1;
                        state_next = rcpi_pkg::ST_RD_J;
                    end
                end
            end
            rcpi_pkg::ST_RD_J:
            begin
                if (j_reg == count_reg || !ok_reg)
                begin
                    if (ok_reg && (!found_reg || t_reg < best_reg))
                    begin
                        found_next    = 1'b1;
                        best_next     = t_reg;
                        best_idx_next = i_reg[IW-1:0];
                    end
                    i_next     = i_reg + CW'(1);
                    state_next = rcpi_pkg::ST_NEXT_I;
                end
                else if (j_reg == i_reg)
                    j_next = j_reg + CW'(1);
                else
                begin
                    rd_addr    = j_reg[IW-1:0];
                    k_next     = 2'd0;
                    acc_next   = '0;
                    state_next = rcpi_pkg::ST_DOT_J;
                end
            end
            rcpi_pkg::ST_DOT_J:
            begin
                rd_addr  = j_reg[IW-1:0];
                acc_next = acc_reg + rcpi_pkg::fshr16(prod_a);
                k_next   = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    if (acc_reg + rcpi_pkg::fshr16(prod_a) > rcpi_pkg::ONE_Q16)
                        ok_next = 1'b0;
                    j_next     = j_reg + CW'(1);
                    state_next = rcpi_pkg::ST_RD_J;
                end
            end
            rcpi_pkg::ST_NRM_RD:
            begin
                rd_addr    = best_idx_reg;
                state_next = rcpi_pkg::ST_NRM_L2;
                k_next     = 2'd0;
                l2_next    = '0;
            end
            rcpi_pkg::ST_NRM_L2:
            begin
                rd_addr = best_idx_reg;
                if (k_reg == 2'd0)
                begin
                    k_next = 2'd1;
                end
                else
                begin
                    l2_next = l2_reg + m_sq;
                    k_next  = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        sh_next    = '0;
                        state_next = rcpi_pkg::ST_NRM_NORM;
                    end
                end
            end
            rcpi_pkg::ST_NRM_NORM:
            begin
                if (l2_reg == 64'd0)
                begin
                    nout_next[0] = '0;
                    nout_next[1] = '0;
                    nout_next[2] = '0;
                    state_next   = rcpi_pkg::ST_OUT;
                end
                else if (l2_reg < (64'd1 << 62))
                begin
                    l2_next = l2_reg << 2;
                    sh_next = sh_reg + 6'd1;
                end
                else
                begin
                    sq_res_next = '0;
                    sq_bit_next = 64'd1 << 62;
                    state_next  = rcpi_pkg::ST_SQRT;
                end
            end
            rcpi_pkg::ST_SQRT:
            begin
                if (sq_bit_reg == 64'd0)
                begin
                    k_next     = 2'd0;
                    state_next = rcpi_pkg::ST_NDIV_START;
                end
                else
                begin
                    if (l2_reg >= sq_try)
                    begin
                        l2_next     = l2_reg - sq_try;
                        sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_res_next = sq_res_reg >> 1;
                    sq_bit_next = sq_bit_reg >> 2;
                end
            end
            rcpi_pkg::ST_NDIV_START:
            begin
                div_start  = 1'b1;
                div_a      = (mag_k << sh_reg) << 30;
                div_b      = sq_res_reg;
                state_next = rcpi_pkg::ST_NDIV;
            end
            rcpi_pkg::ST_NDIV:
            begin
                if (div_done)
                begin
                    nout_next[k_reg] = n_reg[k_reg][31] ? 32'(-div_q) : div_q[31:0];
                    k_next = k_reg + 2'd1;
                    state_next = (k_reg == 2'd2) ? rcpi_pkg::ST_OUT
                                                 : rcpi_pkg::ST_NDIV_START;
                end
            end
            rcpi_pkg::ST_OUT:
            begin
                res_next.hit      = found_reg;
                res_next.distance = found_reg ? best_reg : '0;
                res_next.normal_x = found_reg ? nout_reg[0] : '0;
                res_next.normal_y = found_reg ? nout_reg[1] : '0;
                res_next.normal_z = found_reg ? nout_reg[2] : '0;
                ovalid_next       = 1'b1;
                state_next        = rcpi_pkg::ST_IDLE;
            end
            default: state_next = rcpi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rcpi_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        acc_reg       <= acc_next;
        acc2_reg      <= acc2_next;
        t_reg         <= t_next;
        ok_reg        <= ok_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        ud_reg        <= ud_next;
        un_reg        <= un_next;
        div_phase_reg <= div_phase_next;
        l2_reg        <= l2_next;
        sh_reg        <= sh_next;
        sq_res_reg    <= sq_res_next;
        sq_bit_reg    <= sq_bit_next;
        nout_reg      <= nout_next;
        res_reg       <= res_next;
        if (in_acc)
        begin
            o_reg[0] <= s_axis_tdata[35:4];
            o_reg[1] <= s_axis_tdata[67:36];
            o_reg[2] <= s_axis_tdata[99:68];
            d_reg[0] <= s_axis_tdata[131:100];
            d_reg[1] <= s_axis_tdata[163:132];
            d_reg[2] <= s_axis_tdata[195:164];
        end
        if (state_reg == rcpi_pkg::ST_PT && k_reg != 2'd3)
            p_reg[k_reg] <= rcpi_pkg::sat32(pt_sum);
        if (state_reg == rcpi_pkg::ST_NRM_L2 && k_reg == 2'd0)
        begin
            n_reg[0] <= rd_data_reg[31:0];
            n_reg[1] <= rd_data_reg[63:32];
            n_reg[2] <= rd_data_reg[95:64];
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = res_reg.hit;
    assign m_axis_tdata  = {1'b0, res_reg.normal_z, res_reg.normal_y,
                            res_reg.normal_x, res_reg.distance};

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_busy_no_ready, clk, rst_n,
        !(s_axis_tready && state_reg != rcpi_pkg::ST_IDLE), "ready while busy")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, ovalid_reg && !m_axis_tready,
        ovalid_reg && $stable(res_reg), "result dropped under stall")
    `ASSERT_ALWAYS(a_hit_dist, clk, rst_n,
        !(ovalid_reg && res_reg.hit && res_reg.distance == 31'd0), "hit at zero t")

endmodule

// File: verif/ray_convex_polyhedron_intersect_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_convex_polyhedron_intersect_unit_tb
// Self-checking bench for the ray / convex polyhedron unit. A clocked driver
// sends load and trace items from a queue. A clocked monitor checks every
// result item against a bit-exact fixed-point predictor of the plane walk.
// Both sides idle at random. The bench runs through phases with different
// plane counts and thresholds, and one phase holds the output off for a
// long stretch.
// ---------------------------------------------------------------------------
module ray_convex_polyhedron_intersect_unit_tb;

    localparam int NPLANES      = 16;
    localparam int WATCHDOG_MAX = 20000;
    localparam int LONG_HOLD    = 3000;
    localparam int TARGET_ITEMS = 1500;

    // One input item.
    typedef struct {
        logic [0:0] cmd;
        logic [3:0] idx;
        int         vec [3];
        int         dir [3];
    } ray_item_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [15:0]  cfg_data;

    ray_convex_polyhedron_intersect_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the plane table and the registers.
    int          face_x [NPLANES];
    int          face_y [NPLANES];
    int          face_z [NPLANES];
    logic [4:0]  face_count;
    logic [15:0] min_slope;

    ray_item_t          pending_items [$];
    rcpi_pkg::result_t  hit_queue [$];
    ray_item_t          cur_item;
    int          send_gap;
    int          recv_wait;
    int          hold_req;
    int          hold_done;
    bit          calm;
    int          failures;
    int          issued;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned mag(input longint v);
        mag = (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint dot_q16(input longint a0, a1, a2, b0, b1, b2);
        dot_q16 = ((a0 * b0) >>> 16) + ((a1 * b1) >>> 16) + ((a2 * b2) >>> 16);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            clamp32 = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            clamp32 = -64'sd2147483648;
        else
            clamp32 = v;
    endfunction

    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        root64 = res;
    endfunction

    // One normal component scaled to Q2.30 by the pre-scaled length.
    function automatic logic signed [31:0] unit_comp(input longint c, input int k,
                                                     input longint unsigned s);
        longint unsigned q;
        longint v;
        q = ((mag(c) << k) << 30) / s;
        v = (c < 0) ? -longint'(q) : longint'(q);
        unit_comp = v[31:0];
    endfunction

    // Trace one ray through the active planes and build the result item.
    function automatic rcpi_pkg::result_t trace_ray(input ray_item_t it);
        rcpi_pkg::result_t r;
        longint o [3];
        longint d [3];
        longint n [3];
        longint p [3];
        longint on, dn, num, t, best;
        longint unsigned ud, un, q, rem, l2;
        int cnt, best_idx, k;
        bit ok;
        r = '0;
        best = 0;
        best_idx = -1;
        for (int c = 0; c < 3; c++)
        begin
            o[c] = it.vec[c];
            d[c] = it.dir[c];
        end
        cnt = (face_count > NPLANES) ? NPLANES : face_count;
        for (int i = 0; i < cnt; i++)
        begin
            n[0] = face_x[i];
            n[1] = face_y[i];
            n[2] = face_z[i];
            on = dot_q16(o[0], o[1], o[2], n[0], n[1], n[2]);
            dn = dot_q16(d[0], d[1], d[2], n[0], n[1], n[2]);
            ud = mag(dn);
            if (ud <= min_slope || ud == 0)
                continue;
            num = 64'sd65536 - on;
            if (num == 0 || ((num > 0) != (dn > 0)))
                continue;
            un = mag(num);
            q = un / ud;
            rem = un % ud;
            if (q >= 32768)
                t = 64'h7FFFFFFF;
            else
                t = (q << 16) + ((rem << 16) / ud);
            if (t == 0)
                continue;
            for (int c = 0; c < 3; c++)
                p[c] = clamp32(o[c] + ((t * d[c]) >>> 16));
            ok = 1'b1;
            for (int j = 0; j < cnt && ok; j++)
            begin
                if (j == i)
                    continue;
                if (dot_q16(p[0], p[1], p[2], face_x[j], face_y[j], face_z[j]) > 65536)
                    ok = 1'b0;
            end
            if (ok && (best_idx < 0 || t < best))
            begin
                best = t;
                best_idx = i;
            end
        end
        if (best_idx >= 0)
        begin
            n[0] = face_x[best_idx];
            n[1] = face_y[best_idx];
            n[2] = face_z[best_idx];
            r.hit = 1'b1;
            r.distance = best[30:0];
            l2 = mag(n[0]) * mag(n[0]) + mag(n[1]) * mag(n[1]) + mag(n[2]) * mag(n[2]);
            if (l2 != 0)
            begin
                k = 0;
                while (l2 < (64'd1 << 62))
                begin
                    l2 <<= 2;
                    k++;
                end
                l2 = root64(l2);
                r.normal_x = unit_comp(n[0], k, l2);
                r.normal_y = unit_comp(n[1], k, l2);
                r.normal_z = unit_comp(n[2], k, l2);
            end
        end
        return r;
    endfunction

    // Apply one accepted item to the shadow state and queue its result.
    function automatic void accept_item(input ray_item_t it);
        if (it.cmd == rcpi_pkg::CMD_LOAD)
        begin
            face_x[it.idx] = it.vec[0];
            face_y[it.idx] = it.vec[1];
            face_z[it.idx] = it.vec[2];
            hit_queue.push_back(rcpi_pkg::result_t'('0));
        end
        else
        begin
            hit_queue.push_back(trace_ray(it));
        end
    endfunction

    function automatic int draw_gap();
        if (calm)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= rcpi_pkg::CMD_LOAD;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                accept_item(cur_item);
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item      <= pending_items[0];
                    s_axis_tuser  <= pending_items[0].cmd;
                    s_axis_tdata  <= {4'b0, pending_items[0].dir[2], pending_items[0].dir[1],
                                      pending_items[0].dir[0], pending_items[0].vec[2],
                                      pending_items[0].vec[1], pending_items[0].vec[0],
                                      pending_items[0].idx};
                    void'(pending_items.pop_front());
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= draw_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and result check.
    always @(posedge clk or negedge rst_n)
    begin
        int                wait_n;
        rcpi_pkg::result_t got;
        rcpi_pkg::result_t exp_r;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
            hold_done     <= 0;
        end
        else
        begin
            wait_n = recv_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hit      = m_axis_tuser[0];
                got.distance = m_axis_tdata[30:0];
                got.normal_x = m_axis_tdata[62:31];
                got.normal_y = m_axis_tdata[94:63];
                got.normal_z = m_axis_tdata[126:95];
                if (hit_queue.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    failures++;
                end
                else
                begin
                    exp_r = hit_queue.pop_front();
                    if (got.hit !== exp_r.hit)
                    begin
                        $error("hit: expected %0d, got %0d", exp_r.hit, got.hit);
                        failures++;
                    end
                    if (got.distance !== exp_r.distance)
                    begin
                        $error("distance: expected %0h, got %0h", exp_r.distance,
                               got.distance);
                        failures++;
                    end
                    if (got.normal_x !== exp_r.normal_x)
                    begin
                        $error("normal_x: expected %0h, got %0h", exp_r.normal_x,
                               got.normal_x);
                        failures++;
                    end
                    if (got.normal_y !== exp_r.normal_y)
                    begin
                        $error("normal_y: expected %0h, got %0h", exp_r.normal_y,
                               got.normal_y);
                        failures++;
                    end
                    if (got.normal_z !== exp_r.normal_z)
                    begin
                        $error("normal_z: expected %0h, got %0h", exp_r.normal_z,
                               got.normal_z);
                        failures++;
                    end
                end
                wait_n = draw_gap();
            end
            if (hold_done != hold_req)
            begin
                hold_done <= hold_req;
                wait_n = LONG_HOLD;
            end
            if (wait_n > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_wait     <= wait_n - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_wait     <= 0;
            end
        end
    end

    // Watchdog on cycles without any accepted item or configuration write.
    always @(posedge clk)
    begin
        int idle_cycles;
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        while (1)
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
        if (idx == rcpi_pkg::CFG_PLANE_COUNT)
            face_count = value[4:0];
        else
            min_slope = value;
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && hit_queue.size() == 0 && !s_axis_tvalid);
        repeat (8) @(posedge clk);
    endtask

    task automatic send(input logic [0:0] cmd, input logic [3:0] idx,
                        input int v0, v1, v2, d0, d1, d2);
        ray_item_t it;
        it.cmd = cmd;
        it.idx = idx;
        it.vec[0] = v0;
        it.vec[1] = v1;
        it.vec[2] = v2;
        it.dir[0] = d0;
        it.dir[1] = d1;
        it.dir[2] = d2;
        pending_items.push_back(it);
        issued++;
    endtask

    function automatic int rnd_sym(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Stimulus.
    initial
    begin
        int cnt;
        int ntr;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rcpi_pkg::CFG_PLANE_COUNT;
        cfg_data  = '0;
        failures  = 0;
        issued    = 0;
        hold_req  = 0;
        calm      = 1'b0;
        face_count = 5'd0;
        min_slope  = 16'd1;
        for (int i = 0; i < NPLANES; i++)
        begin
            face_x[i] = 0;
            face_y[i] = 0;
            face_z[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part: a cube of half size 2, a zero normal, a duplicate
        // face, an extreme plane and random filler for the rest.
        write_reg(rcpi_pkg::CFG_PLANE_COUNT, 16'd8);
        write_reg(rcpi_pkg::CFG_THRESHOLD, 16'd0);
        send(rcpi_pkg::CMD_LOAD, 4'd0, 32768, 0, 0, 0, 0, 0);
        send(rcpi_pkg::CMD_LOAD, 4'd1, -32768, 0, 0, 0, 0, 0);
        send(rcpi_pkg::CMD_LOAD, 4'd2, 0, 32768, 0, 0, 0, 0);
        send(rcpi_pkg::CMD_LOAD, 4'd3, 0, -32768, 0, 0, 0, 0);
        send(rcpi_pkg::CMD_LOAD, 4'd4, 0, 0, 32768, 0, 0, 0);
        send(rcpi_pkg::CMD_LOAD, 4'd5, 0, 0, -32768, 0, 0, 0);
        send(rcpi_pkg::CMD_LOAD, 4'd6, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, -1);
        send(rcpi_pkg::CMD_LOAD, 4'd7, 32768, 0, 0, 0, 0, 0);
        send(rcpi_pkg::CMD_LOAD, 4'd8, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
             0, 0, 0);
        for (int i = 9; i < NPLANES; i++)
            send(rcpi_pkg::CMD_LOAD, 4'(i), rnd_sym(65536), rnd_sym(65536),
                 rnd_sym(65536), 0, 0, 0);
        // Equal distance on faces 0 and 7, a parallel ray, a tiny direction with no
        // hit, a zero direction and the extreme field values.
        send(rcpi_pkg::CMD_TRACE, 4'd0, 0, 0, 0, 65536, 0, 0);
        send(rcpi_pkg::CMD_TRACE, 4'd15, 0, 0, 0, 0, 0, 65536);
        send(rcpi_pkg::CMD_TRACE, 4'd0, 0, 0, 0, 1, 0, 0);
        send(rcpi_pkg::CMD_TRACE, 4'd0, 0, 0, 0, 0, 0, 0);
        send(rcpi_pkg::CMD_TRACE, 4'd15, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
             32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        wait_idle();
        write_reg(rcpi_pkg::CFG_PLANE_COUNT, 16'd0);
        send(rcpi_pkg::CMD_TRACE, 4'd3, 0, 0, 0, 65536, 0, 0);
        wait_idle();
        write_reg(rcpi_pkg::CFG_PLANE_COUNT, 16'hFFFF);
        write_reg(rcpi_pkg::CFG_THRESHOLD, 16'hFFFF);
        send(rcpi_pkg::CMD_TRACE, 4'd0, 100, -200, 300, 32'h7FFFFFFF, 32'h80000000,
             65536);
        wait_idle();
        write_reg(rcpi_pkg::CFG_PLANE_COUNT, 16'd16);
        write_reg(rcpi_pkg::CFG_THRESHOLD, 16'd0);
        send(rcpi_pkg::CMD_TRACE, 4'd0, 0, 0, 0, rnd_sym(65536), rnd_sym(65536),
             rnd_sym(65536));
        wait_idle();

        // Random phases: a random polyhedron around the origin, then rays
        // from near its center, with some noise items mixed in.
        for (int ph = 0; issued < TARGET_ITEMS; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       cnt = $urandom_range(0, 31);
                1:       cnt = $urandom_range(7, 10);
                default: cnt = $urandom_range(1, 5);
            endcase
            write_reg(rcpi_pkg::CFG_PLANE_COUNT,
                      16'(cnt) | (16'($urandom_range(0, 2047)) << 5));
            case ($urandom_range(0, 3))
                0:       write_reg(rcpi_pkg::CFG_THRESHOLD, 16'd0);
                1:       write_reg(rcpi_pkg::CFG_THRESHOLD, 16'hFFFF);
                2:       write_reg(rcpi_pkg::CFG_THRESHOLD, 16'($urandom_range(0, 65535)));
                default: write_reg(rcpi_pkg::CFG_THRESHOLD, 16'($urandom_range(0, 64)));
            endcase
            calm = ($urandom_range(0, 4) == 0);
            if (ph == 3)
                hold_req++;
            for (int i = 0; i < NPLANES && i < cnt; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send(rcpi_pkg::CMD_LOAD, 4'(i), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
                else
                    send(rcpi_pkg::CMD_LOAD, 4'(i), rnd_sym(131072), rnd_sym(131072),
                         rnd_sym(131072), $urandom, $urandom, $urandom);
            end
            ntr = (cnt > 6) ? 4 : $urandom_range(8, 25);
            for (int k = 0; k < ntr; k++)
            begin
                case ($urandom_range(0, 9))
                    0:
                        send(rcpi_pkg::CMD_TRACE, 4'($urandom), $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
                    1:
                        send(rcpi_pkg::CMD_LOAD, 4'($urandom), rnd_sym(131072),
                             rnd_sym(131072), rnd_sym(131072), $urandom, $urandom,
                             $urandom);
                    2:
                        send(rcpi_pkg::CMD_TRACE, 4'($urandom), rnd_sym(16384),
                             rnd_sym(16384), rnd_sym(16384), rnd_sym(4), rnd_sym(4),
                             rnd_sym(4));
                    default:
                        send(rcpi_pkg::CMD_TRACE, 4'($urandom), rnd_sym(16384),
                             rnd_sym(16384), rnd_sym(16384), rnd_sym(262144),
                             rnd_sym(262144), rnd_sym(262144));
                endcase
            end
            wait_idle();
        end

        repeat (300) @(posedge clk);
        if (hit_queue.size() != 0)
        begin
            $error("%0d expected result items never arrived", hit_queue.size());
            failures++;
        end
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/rcpi_pkg.sv
sv/rcpi_divider.sv
sv/ray_convex_polyhedron_intersect_unit.sv
verif/ray_convex_polyhedron_intersect_unit_tb.sv
